/* rtl/aesctr_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package aesctr_pkg;

	localparam int BLOCK_BYTES = 16;
	localparam int POS_W = $clog2(BLOCK_BYTES);
	localparam int QUEUE_DEPTH = 4;
	localparam int LAST_ROUND = 10;
	localparam int ROUND_W = 4;

	typedef struct packed {
		logic       valid;
		logic [7:0] data;
		logic       last;
	} q_head_t;

	localparam logic [7:0] SBOX [256] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	function automatic logic [7:0] xtime(input logic [7:0] x);
		return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [7:0] rcon(input logic [ROUND_W-1:0] r);
		logic [7:0] v;
		case (r)
			4'd1: v = 8'h01;
			4'd2: v = 8'h02;
			4'd3: v = 8'h04;
			4'd4: v = 8'h08;
			4'd5: v = 8'h10;
			4'd6: v = 8'h20;
			4'd7: v = 8'h40;
			4'd8: v = 8'h80;
			4'd9: v = 8'h1b;
			4'd10: v = 8'h36;
			default: v = 8'h00;
		endcase
		return v;
	endfunction

	// round key r from round key r-1
	function automatic logic [127:0] next_key(input logic [127:0] rk, input logic [ROUND_W-1:0] r);
		logic [31:0] w0, w1, w2, w3, t;
		w3 = rk[31:0];
		t = {SBOX[w3[23:16]], SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]}
			^ {rcon(r), 24'h0};
		w0 = rk[127:96] ^ t;
		w1 = rk[95:64] ^ w0;
		w2 = rk[63:32] ^ w1;
		w3 = rk[31:0] ^ w2;
		return {w0, w1, w2, w3};
	endfunction

	// SubBytes, ShiftRows and, unless final, MixColumns; byte 0 is the top byte
	function automatic logic [127:0] aes_round(input logic [127:0] st, input logic final_rnd);
		logic [7:0] s [16];
		logic [7:0] t [16];
		logic [7:0] a0, a1, a2, a3, all;
		logic [127:0] res;
		for (int i = 0; i < 16; i++) s[i] = SBOX[st[127-8*i -: 8]];
		for (int c = 0; c < 4; c++)
			for (int i = 0; i < 4; i++) t[i+4*c] = s[i + 4*((c+i)%4)];
		for (int c = 0; c < 4; c++) begin
			a0 = t[4*c];
			a1 = t[4*c+1];
			a2 = t[4*c+2];
			a3 = t[4*c+3];
			all = a0 ^ a1 ^ a2 ^ a3;
			if (!final_rnd) begin
				t[4*c]   = a0 ^ all ^ xtime(a0 ^ a1);
				t[4*c+1] = a1 ^ all ^ xtime(a1 ^ a2);
				t[4*c+2] = a2 ^ all ^ xtime(a2 ^ a3);
				t[4*c+3] = a3 ^ all ^ xtime(a3 ^ a0);
			end
		end
		for (int i = 0; i < 16; i++) res[127-8*i -: 8] = t[i];
		return res;
	endfunction

endpackage

`default_nettype wire

/* rtl/aesctr_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module aesctr_front import aesctr_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] data_in,
	input  wire logic       last_byte,
	input  wire logic       pop,
	output q_head_t         head
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [7:0]    data_mem [DEPTH];
	logic          last_mem [DEPTH];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          push;

	assign in_stall = (count_q == CW'(DEPTH));
	assign push = in_valid && !in_stall;

	assign head.valid = (count_q != '0);
	assign head.data = data_mem[rd_ptr_q];
	assign head.last = last_mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			data_mem[wr_ptr_q] <= data_in;
			last_mem[wr_ptr_q] <= last_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) wr_ptr_q <= (wr_ptr_q == AW'(DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= (rd_ptr_q == AW'(DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

endmodule

`default_nettype wire

/* rtl/aesctr_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module aesctr_back import aesctr_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic [127:0] cfg_key,
	input  wire logic [127:0] cfg_iv,
	input  wire q_head_t      head,
	output logic              pop,
	output logic              out_valid,
	input  wire logic         out_stall,
	output logic [7:0]        data_out,
	output logic              last_out
);

	typedef enum logic {ST_RUN, ST_ENC} state_t;

	state_t             st_q;
	logic [127:0]       key_q, ctr_q, blk_q, rk_q;
	logic [ROUND_W-1:0] round_q;
	logic [POS_W-1:0]   pos_q;
	logic               fresh_q, ks_vld_q;
	logic               out_valid_q;
	logic [7:0]         data_out_q;
	logic               last_out_q;
	logic [127:0]       rk_next;
	logic [127:0]       ctr_src, key_src;
	logic [7:0]         ks_byte;

	assign out_valid = out_valid_q;
	assign data_out = data_out_q;
	assign last_out = last_out_q;

	assign ctr_src = fresh_q ? cfg_iv : ctr_q;
	assign key_src = fresh_q ? cfg_key : key_q;
	assign rk_next = next_key(rk_q, round_q);
	assign ks_byte = blk_q[{~pos_q, 3'b000} +: 8];

	assign pop = (st_q == ST_RUN) && head.valid && ks_vld_q && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_RUN;
			round_q <= '0;
			pos_q <= '0;
			fresh_q <= 1'b1;
			ks_vld_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
			case (st_q)
				ST_RUN: begin
					if (pop) begin
						data_out_q <= head.data ^ ks_byte;
						last_out_q <= head.last;
						if (head.last) pos_q <= '0;
						else pos_q <= pos_q + 1'b1;
						if (pos_q == POS_W'(BLOCK_BYTES-1)) ctr_q <= ctr_q + 128'd1;
						if (head.last || pos_q == POS_W'(BLOCK_BYTES-1)) ks_vld_q <= 1'b0;
						if (head.last) fresh_q <= 1'b1;
					end else if (head.valid && !ks_vld_q) begin
						// start a block: initial round key add
						blk_q <= ctr_src ^ key_src;
						rk_q <= key_src;
						round_q <= ROUND_W'(1);
						if (fresh_q) begin
							ctr_q <= cfg_iv;
							key_q <= cfg_key;
							fresh_q <= 1'b0;
							pos_q <= '0;
						end
						st_q <= ST_ENC;
					end
				end
				ST_ENC: begin
					blk_q <= aes_round(blk_q, round_q == ROUND_W'(LAST_ROUND)) ^ rk_next;
					rk_q <= rk_next;
					round_q <= round_q + 1'b1;
					if (round_q == ROUND_W'(LAST_ROUND)) begin
						ks_vld_q <= 1'b1;
						st_q <= ST_RUN;
					end
				end
				default: st_q <= ST_RUN;
			endcase
		end
	end

endmodule

`default_nettype wire

/* rtl/aes128_ctr_stream_cipher.sv */
`timescale 1ns / 1ps
`default_nettype none

// AES-128 counter-mode byte cipher; encrypt and decrypt are the same operation.
// Key and IV are written over the APB port (key_high 0x00, key_low 0x08,
// iv_high 0x10, iv_low 0x18) and are picked up at the first byte of each
// message. Bytes are queued in a small input FIFO; the back end emits one byte
// per cycle from the current keystream block while bytes are queued and
// out_stall is low. At each block start it adds the initial round key and
// then runs one AES round per cycle, emitting no bytes until it is done. A byte
// with last_byte set ends the message and drops the rest of its keystream block.
module aes128_ctr_stream_cipher import aesctr_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [63:0] pwdata,
	output logic [63:0]      prdata,
	output logic             pready,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  data_in,
	input  wire logic        last_byte,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [7:0]       data_out,
	output logic             last_out
);

	localparam logic [1:0] REG_KEY_HIGH = 2'd0;
	localparam logic [1:0] REG_KEY_LOW  = 2'd1;
	localparam logic [1:0] REG_IV_HIGH  = 2'd2;
	localparam logic [1:0] REG_IV_LOW   = 2'd3;

	logic [63:0] key_high_q, key_low_q, iv_high_q, iv_low_q;
	logic        pop;
	q_head_t     head;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q <= '0;
			key_low_q <= '0;
			iv_high_q <= '0;
			iv_low_q <= '0;
		end else if (psel && penable && pwrite) begin
			case (paddr[4:3])
				REG_KEY_HIGH: key_high_q <= pwdata;
				REG_KEY_LOW:  key_low_q <= pwdata;
				REG_IV_HIGH:  iv_high_q <= pwdata;
				REG_IV_LOW:   iv_low_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:3])
			REG_KEY_HIGH: prdata = key_high_q;
			REG_KEY_LOW:  prdata = key_low_q;
			REG_IV_HIGH:  prdata = iv_high_q;
			REG_IV_LOW:   prdata = iv_low_q;
			default:      prdata = '0;
		endcase
	end

	aesctr_front #(.DEPTH(DEPTH)) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.data_in(data_in),
		.last_byte(last_byte),
		.pop(pop),
		.head(head)
	);

	aesctr_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_key({key_high_q, key_low_q}),
		.cfg_iv({iv_high_q, iv_low_q}),
		.head(head),
		.pop(pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.data_out(data_out),
		.last_out(last_out)
	);

`ifndef SYNTH
	a_pop_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head.valid) else $error("pop from empty queue");
	a_out_from_pop: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(pop)) else $error("result without a dequeued byte");
	a_pop_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (!out_valid || !out_stall)) else $error("output overwritten");
`endif

endmodule

`default_nettype wire
